FILE: hw/rtl/dht_pkg.sv
`timescale 1ns / 1ps

package dht_pkg;

    // Default geometry of the table
    localparam int TABLE_SIZE_DEF = 127;
    localparam int STEP_PRIME_DEF = 13;

    // Fixed field widths
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;
    localparam int COMP_W   = 7;
    localparam int SLOT_W   = 7;
    localparam int MARK_W   = 2;
    localparam int HCNT_W   = $clog2(KEY_W);

    // Operation codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Slot marks
    localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED    = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COMP_W-1:0]   comparisons;
        logic [SLOT_W-1:0]   slot;
    } out_t;

    // One table entry: mark and key share a word
    typedef struct packed {
        logic [MARK_W-1:0] mark;
        logic [KEY_W-1:0]  key;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        HP_IDLE,
        HP_KEY,
        HP_STEP
    } hash_phase_t;

    // Clamp a count to the comparisons field
    function automatic logic [COMP_W-1:0] sat_comp(input logic [31:0] v);
        logic [COMP_W-1:0] r;
        if (v > 32'((1 << COMP_W) - 1)) begin
            r = COMP_W'((1 << COMP_W) - 1);
        end else begin
            r = COMP_W'(v);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/double_hash_table_insert_delete.sv
`timescale 1ns / 1ps
// Flow: the key is hashed, then the probe walk issues one table read a cycle, and the
// result is posted to the output register, where m_ready may hold it.
// One operation at a time: s_ready is high only while idle. The single read port of
// the slot memory sets the pace of the probe walk.
// Reset: aresetn, synchronous, active low; after it a clearing pass marks every slot
// empty, with s_ready low throughout.
module double_hash_table_insert_delete #(
    parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF,
    parameter int STEP_PRIME = dht_pkg::STEP_PRIME_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  dht_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output dht_pkg::out_t m_data
);
    import dht_pkg::*;

    localparam int SW   = $clog2(TABLE_SIZE);
    localparam int CNTW = $clog2(TABLE_SIZE + 1);

    state_t          state_reg, state_next;
    in_t             op_reg, op_next;
    logic [SW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]   next_slot_reg, next_slot_next;
    logic [SW-1:0]   cur_slot_reg, cur_slot_next;
    logic [CNTW-1:0] probe_cnt_reg, probe_cnt_next;
    logic [CNTW-1:0] cur_idx_reg, cur_idx_next;
    logic [CNTW-1:0] comps_reg, comps_next;
    logic            pend_reg, pend_next;
    logic            have_tomb_reg, have_tomb_next;
    logic [SW-1:0]   tomb_reg, tomb_next;
    out_t            res_reg, res_next;
    out_t            m_data_reg, m_data_next;
    logic            m_valid_reg, m_valid_next;

    logic            hash_start, hash_done;
    logic [SW-1:0]   start_slot, step_slot;
    logic            mem_we;
    logic [SW-1:0]   mem_waddr, mem_raddr;
    entry_t          mem_wdata, mem_rdata;

    logic            issue_ok, key_hit;
    logic [SW:0]     adv_sum;
    logic [SW-1:0]   adv_slot, dst_slot;
    logic [CNTW-1:0] comps_inc;

    dht_hash #(
        .TABLE_SIZE(TABLE_SIZE),
        .STEP_PRIME(STEP_PRIME),
        .SW        (SW)
    ) u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (hash_start),
        .key       (op_reg.key),
        .done      (hash_done),
        .start_slot(start_slot),
        .step_slot (step_slot)
    );

    dht_mem #(
        .DEPTH(TABLE_SIZE),
        .AW   (SW)
    ) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Probe address advance and key compare
    always_comb begin
        issue_ok  = probe_cnt_reg < CNTW'(TABLE_SIZE);
        adv_sum   = {1'b0, next_slot_reg} + {1'b0, step_slot};
        if (adv_sum >= (SW + 1)'(TABLE_SIZE)) begin
            adv_slot = SW'(adv_sum - (SW + 1)'(TABLE_SIZE));
        end else begin
            adv_slot = SW'(adv_sum);
        end
        key_hit   = mem_rdata.key == op_reg.key;
        comps_inc = comps_reg + CNTW'(1);
        dst_slot  = have_tomb_reg ? tomb_reg : cur_slot_reg;
    end

    // Sequencer: clear, hash, probe, post
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        clr_cnt_next   = clr_cnt_reg;
        next_slot_next = next_slot_reg;
        cur_slot_next  = cur_slot_reg;
        probe_cnt_next = probe_cnt_reg;
        cur_idx_next   = cur_idx_reg;
        comps_next     = comps_reg;
        pend_next      = pend_reg;
        have_tomb_next = have_tomb_reg;
        tomb_next      = tomb_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        hash_start     = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cur_slot_reg;
        mem_wdata      = '{mark: MARK_USED, key: op_reg.key};
        mem_raddr      = next_slot_reg;
        s_ready        = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '{mark: MARK_EMPTY, key: '0};
                if (clr_cnt_reg == SW'(TABLE_SIZE - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + SW'(1);
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_data;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                hash_start = !hash_done;
                if (hash_done) begin
                    next_slot_next = start_slot;
                    probe_cnt_next = '0;
                    pend_next      = 1'b0;
                    comps_next     = '0;
                    have_tomb_next = 1'b0;
                    tomb_next      = '0;
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (pend_reg) begin
                    // Judge the slot whose read was issued last cycle
                    if (op_reg.mode == MODE_INSERT) begin
                        if (mem_rdata.mark == MARK_EMPTY) begin
                            mem_we     = 1'b1;
                            mem_waddr  = dst_slot;
                            res_next   = '{status: STAT_INSERTED,
                                          comparisons: sat_comp(32'(comps_reg)),
                                          slot: SLOT_W'(dst_slot)};
                            state_next = ST_FIN;
                        end else if (mem_rdata.mark == MARK_DELETED) begin
                            if (!have_tomb_reg) begin
                                have_tomb_next = 1'b1;
                                tomb_next      = cur_slot_reg;
                            end
                        end else begin
                            comps_next = comps_inc;
                            if (key_hit) begin
                                res_next   = '{status: STAT_DUPLICATE,
                                              comparisons: sat_comp(32'(comps_inc)),
                                              slot: '0};
                                state_next = ST_FIN;
                            end
                        end
                    end else begin
                        if (mem_rdata.mark == MARK_USED && key_hit) begin
                            mem_we     = 1'b1;
                            mem_wdata  = '{mark: MARK_DELETED, key: op_reg.key};
                            res_next   = '{status: STAT_DELETED,
                                          comparisons: sat_comp(32'(cur_idx_reg) + 32'd1),
                                          slot: SLOT_W'(cur_slot_reg)};
                            state_next = ST_FIN;
                        end
                    end
                end else if (!issue_ok) begin
                    // Every probe seen without a decision
                    state_next = ST_FIN;
                    if (op_reg.mode == MODE_INSERT) begin
                        if (have_tomb_reg) begin
                            mem_we    = 1'b1;
                            mem_waddr = tomb_reg;
                            res_next  = '{status: STAT_INSERTED,
                                         comparisons: sat_comp(32'(comps_reg)),
                                         slot: SLOT_W'(tomb_reg)};
                        end else begin
                            res_next = '{status: STAT_FULL,
                                        comparisons: sat_comp(32'(TABLE_SIZE)),
                                        slot: '0};
                        end
                    end else begin
                        res_next = '{status: STAT_NOT_FOUND, comparisons: '0, slot: '0};
                    end
                end
                // Advance the read pipeline unless the operation ends here
                if (state_next == ST_PROBE) begin
                    pend_next     = issue_ok;
                    cur_slot_next = next_slot_reg;
                    cur_idx_next  = probe_cnt_reg;
                    if (issue_ok) begin
                        next_slot_next = adv_slot;
                        probe_cnt_next = probe_cnt_reg + CNTW'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_FIN: begin
                // Hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    pend_next    = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        next_slot_reg <= next_slot_next;
        cur_slot_reg  <= cur_slot_next;
        probe_cnt_reg <= probe_cnt_next;
        cur_idx_reg   <= cur_idx_next;
        comps_reg     <= comps_next;
        have_tomb_reg <= have_tomb_next;
        tomb_reg      <= tomb_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    // Table writes only during the clearing pass or at the end of a probe walk
    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_PROBE))
        else $error("slot memory written outside clear or probe");

    // A pending probe never lies beyond the table
    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (32'(cur_idx_reg) < TABLE_SIZE && state_reg == ST_PROBE))
        else $error("pending probe out of range");

    // An accepted beat starts hashing on the next cycle
    a_accept_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_HASH))
        else $error("accepted beat did not start hashing");
`endif

endmodule

FILE: hw/rtl/dht_mem.sv
`timescale 1ns / 1ps

module dht_mem #(
    parameter int DEPTH = dht_pkg::TABLE_SIZE_DEF,
    parameter int AW    = $clog2(dht_pkg::TABLE_SIZE_DEF)
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  dht_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output dht_pkg::entry_t rdata
);
    import dht_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/dht_hash.sv
`timescale 1ns / 1ps

module dht_hash #(
    parameter int TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF,
    parameter int STEP_PRIME = dht_pkg::STEP_PRIME_DEF,
    parameter int SW         = $clog2(dht_pkg::TABLE_SIZE_DEF)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [dht_pkg::KEY_W-1:0] key,
    output logic                      done,
    output logic [SW-1:0]             start_slot,
    output logic [SW-1:0]             step_slot
);
    import dht_pkg::*;

    localparam int SPW = $clog2(STEP_PRIME + 1);
    localparam int RTW = $clog2(2 * TABLE_SIZE);
    localparam int RPW = $clog2(2 * STEP_PRIME);
    // Reciprocals scaled by 2^32: the quotient they give is low by at most one
    localparam logic [32:0] RECIP_T = 33'((64'd1 << 32) / 64'(TABLE_SIZE));
    localparam logic [32:0] RECIP_P = 33'((64'd1 << 32) / 64'(STEP_PRIME));

    hash_phase_t       phase_reg, phase_next;
    logic [HCNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [63:0]       prod_t_reg, prod_t_next;
    logic [63:0]       prod_p_reg, prod_p_next;
    logic [RTW-1:0]    rt_reg, rt_next;
    logic [RPW-1:0]    rp_reg, rp_next;
    logic [SPW-1:0]    sv_reg, sv_next;
    logic [63:0]       prod_s_reg, prod_s_next;
    logic [RTW-1:0]    rs_reg, rs_next;
    logic [SW-1:0]     r1_reg, r1_next;
    logic [SW-1:0]     r3_reg, r3_next;
    logic              done_reg, done_next;

    logic [63:0]       diff_t, diff_p, diff_s;
    logic [RPW-1:0]    rp_fix;

    // Remainder estimates: value less estimated quotient times modulus, below twice the modulus
    always_comb begin
        diff_t = 64'(key_reg) - 64'(prod_t_reg[63:32]) * 64'(TABLE_SIZE);
        diff_p = 64'(key_reg) - 64'(prod_p_reg[63:32]) * 64'(STEP_PRIME);
        diff_s = 64'(sv_reg) - 64'(prod_s_reg[63:32]) * 64'(TABLE_SIZE);
        if (rp_reg >= RPW'(STEP_PRIME)) begin
            rp_fix = rp_reg - RPW'(STEP_PRIME);
        end else begin
            rp_fix = rp_reg;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        prod_t_next = prod_t_reg;
        prod_p_next = prod_p_reg;
        rt_next     = rt_reg;
        rp_next     = rp_reg;
        sv_next     = sv_reg;
        prod_s_next = prod_s_reg;
        rs_next     = rs_reg;
        r1_next     = r1_reg;
        r3_next     = r3_reg;
        done_next   = 1'b0;
        case (phase_reg)
            HP_IDLE: begin
                // Multiply the key by both reciprocals
                if (start) begin
                    key_next    = key;
                    prod_t_next = 64'(key) * 64'(RECIP_T);
                    prod_p_next = 64'(key) * 64'(RECIP_P);
                    cnt_next    = '0;
                    phase_next  = HP_KEY;
                end
            end
            HP_KEY: begin
                if (cnt_reg == '0) begin
                    // Take the remainder estimates
                    rt_next  = diff_t[RTW-1:0];
                    rp_next  = diff_p[RPW-1:0];
                    cnt_next = HCNT_W'(1);
                end else begin
                    // One compare and subtract settles each remainder
                    if (rt_reg >= RTW'(TABLE_SIZE)) begin
                        r1_next = SW'(rt_reg - RTW'(TABLE_SIZE));
                    end else begin
                        r1_next = SW'(rt_reg);
                    end
                    sv_next    = SPW'(rp_fix) + SPW'(1);
                    cnt_next   = '0;
                    phase_next = HP_STEP;
                end
            end
            HP_STEP: begin
                // Reduce the step modulo the table size the same way
                if (cnt_reg == '0) begin
                    prod_s_next = 64'(sv_reg) * 64'(RECIP_T);
                    cnt_next    = HCNT_W'(1);
                end else if (cnt_reg == HCNT_W'(1)) begin
                    rs_next  = diff_s[RTW-1:0];
                    cnt_next = HCNT_W'(2);
                end else begin
                    if (rs_reg >= RTW'(TABLE_SIZE)) begin
                        r3_next = SW'(rs_reg - RTW'(TABLE_SIZE));
                    end else begin
                        r3_next = SW'(rs_reg);
                    end
                    done_next  = 1'b1;
                    phase_next = HP_IDLE;
                end
            end
            default: begin
                phase_next = HP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= HP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        key_reg    <= key_next;
        prod_t_reg <= prod_t_next;
        prod_p_reg <= prod_p_next;
        rt_reg     <= rt_next;
        rp_reg     <= rp_next;
        sv_reg     <= sv_next;
        prod_s_reg <= prod_s_next;
        rs_reg     <= rs_next;
        r1_reg     <= r1_next;
        r3_reg     <= r3_next;
    end

    assign done       = done_reg;
    assign start_slot = r1_reg;
    assign step_slot  = r3_reg;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import dht_pkg::*;

    localparam int unsigned TBL        = TABLE_SIZE_DEF;
    localparam int unsigned STEP_MOD   = STEP_PRIME_DEF;
    localparam int          CALM_TAIL  = 60;
    localparam int          DRAIN_WAIT = 200;
    localparam int          STALL_MAX  = 3000;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Operations waiting to be driven and outcomes waiting to be returned
    in_t  op_queue[$];
    out_t expected_outcomes[$];

    // Shadow copy of the table
    logic [MARK_W-1:0] shadow_mark[TBL];
    logic [KEY_W-1:0]  shadow_key[TBL];

    int   mismatch_count = 0;
    int   result_count   = 0;
    int   gap_left       = 0;
    int   stall_left     = 0;
    int   quiet_left     = 0;
    int   dead_cycles    = 0;
    out_t want;

    double_hash_table_insert_delete u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40) begin
            $display("MISMATCH: %s", msg);
        end
        mismatch_count++;
    endtask

    task automatic push_op(input logic mode, input logic [KEY_W-1:0] key);
        in_t b;
        b.mode = mode;
        b.key  = key;
        op_queue.push_back(b);
    endtask

    // Idling only outside quiet stretches and the closing part of the run
    function automatic bit idle_allowed();
        return (op_queue.size() >= CALM_TAIL) && (quiet_left == 0);
    endfunction

    // Walk the probe sequence of one operation and update the shadow table
    function automatic out_t hash_table_predict(input in_t op);
        out_t        res;
        int unsigned step, pos, tomb, comps, probe;
        bit          have_tomb, settled;
        res       = '0;
        step      = op.key % STEP_MOD + 1;
        pos       = op.key % TBL;
        tomb      = 0;
        comps     = 0;
        have_tomb = 1'b0;
        settled   = 1'b0;
        if (op.mode == MODE_INSERT) begin
            for (probe = 0; probe < TBL && !settled; probe++) begin
                if (shadow_mark[pos] == MARK_EMPTY) begin
                    if (!have_tomb) begin
                        tomb = pos;
                    end
                    shadow_key[tomb]  = op.key;
                    shadow_mark[tomb] = MARK_USED;
                    res.status      = STAT_INSERTED;
                    res.comparisons = COMP_W'(comps);
                    res.slot        = SLOT_W'(tomb);
                    settled = 1'b1;
                end else if (shadow_mark[pos] == MARK_DELETED) begin
                    if (!have_tomb) begin
                        have_tomb = 1'b1;
                        tomb      = pos;
                    end
                end else begin
                    comps++;
                    if (shadow_key[pos] == op.key) begin
                        res.status      = STAT_DUPLICATE;
                        res.comparisons = COMP_W'(comps > 127 ? 127 : comps);
                        settled = 1'b1;
                    end
                end
                pos = (pos + step) % TBL;
            end
            if (!settled && have_tomb) begin
                shadow_key[tomb]  = op.key;
                shadow_mark[tomb] = MARK_USED;
                res.status      = STAT_INSERTED;
                res.comparisons = COMP_W'(comps > 127 ? 127 : comps);
                res.slot        = SLOT_W'(tomb);
            end else if (!settled) begin
                res.status      = STAT_FULL;
                res.comparisons = COMP_W'(TBL > 127 ? 127 : TBL);
            end
        end else begin
            for (probe = 0; probe < TBL && !settled; probe++) begin
                if (shadow_mark[pos] == MARK_USED && shadow_key[pos] == op.key) begin
                    shadow_mark[pos] = MARK_DELETED;
                    res.status      = STAT_DELETED;
                    res.comparisons = COMP_W'(probe + 1 > 127 ? 127 : probe + 1);
                    res.slot        = SLOT_W'(pos);
                    settled = 1'b1;
                end
                pos = (pos + step) % TBL;
            end
            if (!settled) begin
                res.status = STAT_NOT_FOUND;
            end
        end
        return res;
    endfunction

    // Quiet stretches: no idling on either side for a while
    always @(posedge aclk) begin
        if (quiet_left != 0) begin
            quiet_left <= quiet_left - 1;
        end else if ($urandom_range(0, 199) == 0) begin
            quiet_left <= $urandom_range(30, 90);
        end
    end

    // Driver: predict each accepted beat, then present the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_outcomes.push_back(hash_table_predict(s_data));
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (op_queue.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= $urandom_range(0, 6);
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= op_queue.pop_front();
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest outcome, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              result_count));
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_data.status !== want.status) begin
                        report_mismatch($sformatf("result %0d status got %0d want %0d",
                                                  result_count, m_data.status, want.status));
                    end
                    if (m_data.comparisons !== want.comparisons) begin
                        report_mismatch($sformatf("result %0d comparisons got %0d want %0d",
                                                  result_count, m_data.comparisons,
                                                  want.comparisons));
                    end
                    if (m_data.slot !== want.slot) begin
                        report_mismatch($sformatf("result %0d slot got %0d want %0d",
                                                  result_count, m_data.slot, want.slot));
                    end
                end
                result_count <= result_count + 1;
            end
            if (stall_left != 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (idle_allowed() && $urandom_range(0, 6) == 0) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            dead_cycles <= 0;
        end else begin
            dead_cycles <= dead_cycles + 1;
        end
        if (dead_cycles >= STALL_MAX) begin
            $display("watchdog: no beat for %0d cycles", dead_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int               j;
        logic [KEY_W-1:0] pool[48];
        logic [KEY_W-1:0] fill[135];

        for (j = 0; j < int'(TBL); j++) begin
            shadow_mark[j] = MARK_EMPTY;
            shadow_key[j]  = '0;
        end

        // Directed: empty table, extremes, collisions on slot 0, tombstone reuse
        push_op(MODE_DELETE, 31'd5);
        push_op(MODE_INSERT, 31'd0);
        push_op(MODE_INSERT, KEY_MAX);
        push_op(MODE_INSERT, 31'd0);
        push_op(MODE_INSERT, 31'd127);
        push_op(MODE_INSERT, 31'd254);
        push_op(MODE_DELETE, 31'd0);
        push_op(MODE_INSERT, 31'd381);
        push_op(MODE_DELETE, 31'd0);
        push_op(MODE_DELETE, KEY_MAX);
        push_op(MODE_INSERT, KEY_MAX);
        push_op(MODE_INSERT, 31'h5555_5555);
        push_op(MODE_INSERT, 31'h2AAA_AAAA);
        push_op(MODE_INSERT, 31'd1);
        push_op(MODE_INSERT, 31'h4000_0000);
        push_op(MODE_DELETE, 31'd127);
        push_op(MODE_DELETE, 31'd254);
        push_op(MODE_INSERT, 31'd381);
        push_op(MODE_DELETE, 31'd381);
        push_op(MODE_DELETE, 31'd381);
        push_op(MODE_INSERT, 31'd254);
        push_op(MODE_DELETE, 31'h5555_5555);
        push_op(MODE_DELETE, 31'h2AAA_AAAA);

        // Key pool: small keys, keys sharing a home slot, full-range keys
        for (j = 0; j < 48; j++) begin
            case (j % 3)
                0: pool[j] = KEY_W'($urandom_range(0, 300));
                1: pool[j] = KEY_W'(($urandom_range(0, 3) * TBL)
                                    + $urandom_range(0, 1) * (TBL * 1000));
                default: pool[j] = KEY_W'($urandom);
            endcase
        end

        // Mixed traffic on the pool, weighted to inserts
        for (j = 0; j < 280; j++) begin
            push_op($urandom_range(0, 2) == 0 ? MODE_DELETE : MODE_INSERT,
                    pool[$urandom_range(0, 47)]);
        end

        // Fill the table to the brim, then hit it while full
        for (j = 0; j < 135; j++) begin
            fill[j] = KEY_W'($urandom);
            push_op(MODE_INSERT, fill[j]);
        end
        for (j = 0; j < 10; j++) begin
            push_op(MODE_INSERT, KEY_W'($urandom));
        end
        for (j = 0; j < 10; j++) begin
            push_op(MODE_INSERT, fill[$urandom_range(0, 134)]);
        end

        // Punch tombstones into the full table and refill them with no empty slot left
        for (j = 0; j < 25; j++) begin
            push_op(MODE_DELETE, fill[j * 5]);
        end
        for (j = 0; j < 25; j++) begin
            push_op(MODE_INSERT, KEY_W'($urandom));
        end
        for (j = 0; j < 5; j++) begin
            push_op(MODE_DELETE, KEY_W'($urandom));
        end

        // Drain the table down to tombstones, then mix again
        for (j = 0; j < 135; j++) begin
            push_op(MODE_DELETE, fill[j]);
        end
        for (j = 0; j < 48; j++) begin
            push_op(MODE_DELETE, pool[j]);
        end
        for (j = 0; j < 150; j++) begin
            push_op($urandom_range(0, 1) == 0 ? MODE_DELETE : MODE_INSERT,
                    $urandom_range(0, 3) == 0 ? KEY_W'($urandom)
                                              : pool[$urandom_range(0, 47)]);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Hold until every beat has gone in and every outcome has come back
        while (op_queue.size() != 0 || s_valid || expected_outcomes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (expected_outcomes.size() != 0) begin
            report_mismatch($sformatf("%0d outcomes never returned",
                                      expected_outcomes.size()));
        end
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
